/* design/assert_macros.svh */
// Assertion macros shared by the top-k tracker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TKT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("top-k tracker check failed");
`define TKT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("top-k tracker check failed");
`else
`define TKT_ASSERT(label, clk, rst, prop)
`define TKT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* design/tkt_pkg.sv */
// Types, constants and helpers of the top-k tracker
package tkt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int TAG_BITS    = 16;
   localparam int KEY_BITS    = 31;
   localparam int KEEP_BITS   = 5;
   localparam int KEEP_RESET  = 3;
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_SHIFT  = 2'd2;
   localparam logic [1:0] CELL_CLEAR  = 2'd3;

   typedef struct packed {
      logic                used;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } cell_ctrl_type;

   function automatic logic [CNT_BITS-1:0] effective_keep(input logic [KEEP_BITS-1:0] k);
      int v;
      v = int'(k);
      if (v == 0) begin
         v = 1;
      end
      if (v > MAX_ENTRIES) begin
         v = MAX_ENTRIES;
      end
      return CNT_BITS'(v);
   endfunction

endpackage

/* design/tkt_if.sv */
// Channel interfaces of the top-k tracker: request, response and control write
interface tkt_req_if;
   import tkt_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [KEY_BITS-1:0] item_key;
   logic [TAG_BITS-1:0] item_tag;
   modport source (output valid, op, item_key, item_tag, input ready);
   modport sink (input valid, op, item_key, item_tag, output ready);
endinterface

interface tkt_rsp_if;
   import tkt_pkg::*;
   logic                valid;
   logic                ready;
   logic [KEY_BITS-1:0] out_key;
   logic [TAG_BITS-1:0] out_tag;
   logic                out_valid;
   logic                out_last;
   modport source (output valid, out_key, out_tag, out_valid, out_last, input ready);
   modport sink (input valid, out_key, out_tag, out_valid, out_last, output ready);
endinterface

interface tkt_csr_if;
   import tkt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KEEP_BITS-1:0] keep_count;
   modport source (output valid, keep_count, input ready);
   modport sink (input valid, keep_count, output ready);
endinterface

/* design/top_k_tracker.sv */
// Top level of the top-k tracker: cell chain, flush sequencer and output register
//
// Keeps the largest keys seen, sorted largest first, in a chain of
// MAX_ENTRIES cells; equal keys stay in arrival order. Inserts are accepted
// back to back, also while a response waits in the output register. A flush
// item shifts the chain toward cell 0 one entry per cycle while the output
// register can take an item, and sends min(stored, keep) response items, or
// one item marked not valid when the store is empty, then clears the chain;
// req ready stays low until the last item is in the output register. Keep
// count 0 acts as 1 and values above MAX_ENTRIES act as MAX_ENTRIES; write
// it only while the block is idle.
`include "assert_macros.svh"

module top_k_tracker (
   input logic      clock,
   input logic      reset,
   tkt_req_if.sink  req_ch,
   tkt_rsp_if.source rsp_ch,
   tkt_csr_if.sink  csr_ch
);
   import tkt_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_FLUSH = 1'b1;

   logic                 state_ff, state_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [KEEP_BITS-1:0] keep_ff, keep_in;
   logic [CNT_BITS-1:0]  keep_n;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]  rsp_key_ff, rsp_key_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic                 rsp_last_ff, rsp_last_in;

   cell_ctrl_type        ctrl;
   entry_type            entries [MAX_ENTRIES];
   entry_type            prev_w [MAX_ENTRIES];
   entry_type            next_w [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] take_w;
   logic [MAX_ENTRIES-1:0] prev_take_w;
   logic [MAX_ENTRIES-1:0] keep_mask;
   logic [MAX_ENTRIES-1:0] used_vec;

   logic req_fire, ins_fire, slot_free, emit, emit_last;

   assign keep_n       = effective_keep(keep_ff);
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign ins_fire     = req_fire && (req_ch.op == OP_INSERT);
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign emit         = (state_ff == ST_FLUSH) && slot_free;
   assign emit_last    = !entries[0].used || !entries[1].used ||
                         ((idx_ff + CNT_BITS'(1)) == keep_n);

   always_comb begin
      ctrl.key = req_ch.item_key;
      ctrl.tag = req_ch.item_tag;
      if (ins_fire) begin
         ctrl.cmd = CELL_INSERT;
      end else if (emit) begin
         ctrl.cmd = emit_last ? CELL_CLEAR : CELL_SHIFT;
      end else begin
         ctrl.cmd = CELL_HOLD;
      end
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_w[g]      = '0;
         assign prev_take_w[g] = 1'b0;
      end else begin : g_body
         assign prev_w[g]      = entries[g-1];
         assign prev_take_w[g] = take_w[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_tail
         assign next_w[g] = '0;
      end else begin : g_mid
         assign next_w[g] = entries[g+1];
      end
      assign keep_mask[g] = (CNT_BITS'(g) < keep_n);
      assign used_vec[g]  = entries[g].used;

      tkt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .keep_ok    (keep_mask[g]),
         .prev_entry (prev_w[g]),
         .prev_take  (prev_take_w[g]),
         .next_entry (next_w[g]),
         .take       (take_w[g]),
         .entry      (entries[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      keep_in  = keep_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         keep_in = csr_ch.keep_count;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.op == OP_FLUSH)) begin
               state_in = ST_FLUSH;
               idx_in   = '0;
            end
         end
         ST_FLUSH: begin
            if (emit) begin
               idx_in = idx_ff + CNT_BITS'(1);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = entries[0].used;
         rsp_key_in   = entries[0].used ? entries[0].key : '0;
         rsp_tag_in   = entries[0].used ? entries[0].tag : '0;
         rsp_last_in  = emit_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         keep_ff      <= KEEP_BITS'(KEEP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff  <= rsp_key_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_key   = rsp_key_ff;
   assign rsp_ch.out_tag   = rsp_tag_ff;
   assign rsp_ch.out_valid = rsp_ok_ff;
   assign rsp_ch.out_last  = rsp_last_ff;

   `TKT_ASSERT(a_used_prefix, clock, reset, ((used_vec & (used_vec + MAX_ENTRIES'(1))) == '0))
   `TKT_ASSERT(a_insert_cut, clock, reset, ins_fire |=> ((used_vec & ~$past(keep_mask)) == '0))
   `TKT_ASSERT(a_flush_clears, clock, reset, (emit && emit_last) |=> (used_vec == '0))
   `TKT_ASSERT_ALWAYS(a_empty_is_last, clock, (rsp_valid_ff && !rsp_ok_ff) |-> rsp_last_ff)

endmodule

/* design/tkt_cell.sv */
// One cell of the sorted chain: holds an entry, inserts, shifts or clears
module tkt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tkt_pkg::cell_ctrl_type ctrl,
   input  logic                  keep_ok,
   input  tkt_pkg::entry_type    prev_entry,
   input  logic                  prev_take,
   input  tkt_pkg::entry_type    next_entry,
   output logic                  take,
   output tkt_pkg::entry_type    entry
);
   import tkt_pkg::*;

   logic                used_ff, used_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   assign take  = !used_ff || (key_ff < ctrl.key);
   assign entry = '{used: used_ff, key: key_ff, tag: tag_ff};

   always_comb begin
      used_in = used_ff;
      key_in  = key_ff;
      tag_in  = tag_ff;
      case (ctrl.cmd)
         CELL_INSERT: begin
            if (!keep_ok) begin
               used_in = 1'b0;
            end else if (take && prev_take) begin
               used_in = prev_entry.used;
               key_in  = prev_entry.key;
               tag_in  = prev_entry.tag;
            end else if (take) begin
               used_in = 1'b1;
               key_in  = ctrl.key;
               tag_in  = ctrl.tag;
            end
         end
         CELL_SHIFT: begin
            used_in = next_entry.used;
            key_in  = next_entry.key;
            tag_in  = next_entry.tag;
         end
         CELL_CLEAR: begin
            used_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule
